// File: hw/rtl/calendar_period_length_days_core_assert.svh
// Assertion macros shared by the period length core modules.
`ifndef CALENDAR_PERIOD_LENGTH_DAYS_CORE_ASSERT_SVH
`define CALENDAR_PERIOD_LENGTH_DAYS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CPLD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CPLD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cpld_pkg.sv
// Types, constants and calendar tables for the period length core.
`default_nettype none

package cpld_pkg;

  localparam logic [13:0] MAX_YEAR = 14'd9999;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 16384
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [13:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic        include_end_day;
  } req_t;

  typedef struct packed {
    logic [21:0] day_count;
    logic        date_invalid;
  } res_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;
    logic sel_end;
    logic prep;
    logic conv;
    logic finish;
  } cmd_t;

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                  v = 5'd30;
      4'd2:                                     v = leap ? 5'd29 : 5'd28;
      default:                                  v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cpld_ctrl.sv
// Sequencer for the period length core: walks start date, end date, result.
`default_nettype none

module cpld_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output cpld_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PREP_S = 6'b000010,
    ST_CONV_S = 6'b000100,
    ST_PREP_E = 6'b001000,
    ST_CONV_E = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    unique case (state)
      ST_IDLE:   state_next = start ? ST_PREP_S : ST_IDLE;
      ST_PREP_S: state_next = ST_CONV_S;
      ST_CONV_S: state_next = ST_PREP_E;
      ST_PREP_E: state_next = ST_CONV_E;
      ST_CONV_E: state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy        = (state != ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && start;
  assign cmd.sel_end = (state == ST_PREP_E) || (state == ST_CONV_E);
  assign cmd.prep    = (state == ST_PREP_S) || (state == ST_PREP_E);
  assign cmd.conv    = (state == ST_CONV_S) || (state == ST_CONV_E);
  assign cmd.finish  = (state == ST_FINISH);

`include "calendar_period_length_days_core_assert.svh"

  `CPLD_ASSERT_NXT(a_capture_starts, clk, rst, cmd.capture, state == ST_PREP_S, "capture did not start conversion")
  `CPLD_ASSERT_NXT(a_finish_to_idle, clk, rst, cmd.finish, !busy, "still busy after finish")
  `CPLD_ASSERT_IMP(a_conv_after_prep, clk, rst, cmd.conv, $past(cmd.prep), "conversion without prep")

endmodule

`default_nettype wire

// File: hw/rtl/cpld_dp.sv
// Datapath: date to serial day conversion, validity check and difference.
`default_nettype none

module cpld_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cpld_pkg::req_t  req,
  input  wire cpld_pkg::cmd_t  cmd,
  output logic                 done,
  output cpld_pkg::res_t       res
);

  cpld_pkg::req_t req_q;

  logic [13:0] y;
  logic [3:0]  m;
  logic [4:0]  d;

  // stage 1 products
  logic [13:0] p;
  logic [26:0] prod_p;
  logic [24:0] prod_p4;
  logic [26:0] prod_y;

  logic [13:0] p_q;
  logic [7:0]  qp_q;
  logic [5:0]  qp4_q;
  logic [7:0]  qy_q;

  // stage 2
  logic [13:0] rem_y;
  logic        leap;
  logic [4:0]  dim;
  logic        valid;
  logic [22:0] serial;

  logic [21:0] a_q;
  logic [21:0] b_q;
  logic        bad_q;

  logic [21:0] diff;
  logic [21:0] count;

  assign y = cmd.sel_end ? req_q.end_year  : req_q.start_year;
  assign m = cmd.sel_end ? req_q.end_month : req_q.start_month;
  assign d = cmd.sel_end ? req_q.end_day   : req_q.start_day;

  assign p       = y - 14'd1;
  assign prod_p  = 27'(p) * 27'(cpld_pkg::RECIP_100);
  assign prod_p4 = 25'(p[13:2]) * 25'(cpld_pkg::RECIP_100);
  assign prod_y  = 27'(y) * 27'(cpld_pkg::RECIP_100);

  // y % 100 from the registered quotient; y % 400 == 0 iff y % 100 == 0 and (y/100) % 4 == 0
  assign rem_y = y - (14'(qy_q) * 14'd100);
  assign leap  = ((y[1:0] == 2'd0) && (rem_y != 14'd0)) ||
                 ((rem_y == 14'd0) && (qy_q[1:0] == 2'd0));
  assign dim   = cpld_pkg::month_days(m, leap);
  assign valid = (y != 14'd0) && (y <= cpld_pkg::MAX_YEAR) &&
                 (m >= 4'd1) && (m <= 4'd12) &&
                 (d != 5'd0) && (d <= dim);

  assign serial = (23'(p_q) * 23'd365) + 23'(p_q[13:2]) - 23'(qp_q) + 23'(qp4_q)
                + 23'(cpld_pkg::days_before(m)) + 23'(leap && (m > 4'd2)) + 23'(d);

  assign diff  = b_q - a_q;
  assign count = ((a_q < b_q) ? diff : 22'd0) + 22'(req_q.include_end_day);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.prep) begin
      p_q   <= p;
      qp_q  <= prod_p[cpld_pkg::RECIP_SHIFT +: 8];
      qp4_q <= prod_p4[cpld_pkg::RECIP_SHIFT +: 6];
      qy_q  <= prod_y[cpld_pkg::RECIP_SHIFT +: 8];
    end
    if (cmd.conv) begin
      if (cmd.sel_end) begin
        b_q <= serial[21:0];
      end else begin
        a_q <= serial[21:0];
      end
    end
    if (cmd.finish) begin
      res.day_count    <= bad_q ? 22'd0 : count;
      res.date_invalid <= bad_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_q <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.capture) begin
        bad_q <= 1'b0;
      end else if (cmd.conv && !valid) begin
        bad_q <= 1'b1;
      end
    end
  end

`include "calendar_period_length_days_core_assert.svh"

  `CPLD_ASSERT_IMP(a_invalid_zero, clk, rst, done && res.date_invalid, res.day_count == 22'd0, "invalid date with nonzero count")
  `CPLD_ASSERT_IMP(a_done_single, clk, rst, done, !$past(done), "result strobe held two cycles")
  `CPLD_ASSERT_NXT(a_capture_clears_bad, clk, rst, cmd.capture, !bad_q, "error flag not cleared on capture")

endmodule

`default_nettype wire

// File: hw/rtl/calendar_period_length_days_core.sv
// Top level of the Gregorian period length core.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  request  | start / busy       | req (start and end date, include flag)
//  result   | done (strobe)      | res (day_count, date_invalid)
//
// A transaction is taken at a rising edge with start high and busy low.
// The result strobe done rises once FINISH has passed, for one cycle: for
// each date, the /100 reciprocal multiplier is registered in a PREP state
// and the serial day adder in a CONV state; the difference is registered
// in FINISH. busy is low again in the done cycle, so a new transaction can
// be taken there; none is taken while busy is high. Synchronous reset
// returns to idle and drops done; the result side cannot stall.
`default_nettype none

module calendar_period_length_days_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire cpld_pkg::req_t  req,
  output logic                 done,
  output cpld_pkg::res_t       res
);

  cpld_pkg::cmd_t cmd;

  cpld_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  cpld_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .done (done),
    .res  (res)
  );

endmodule

`default_nettype wire

// File: bench/calendar_period_length_days_checker.sv
// Checker for the period length core: predicts each day count and compares results.
module calendar_period_length_days_checker
  import cpld_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  res_t res,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    req_t q;
    res_t r;
  } period_expect_t;

  period_expect_t expected_periods[$];

  initial errors = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ERROR: %s", $time, what);
    errors++;
  endtask

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // zero for a month outside 1..12
  function automatic int unsigned month_len(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit valid_date(int unsigned y, int unsigned m, int unsigned d);
    return y >= 1 && y <= MAX_YEAR && month_len(y, m) != 0 && d >= 1 &&
           d <= month_len(y, m);
  endfunction

  // 0001-01-01 is day 1
  function automatic int unsigned day_number(int unsigned y, int unsigned m,
                                             int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++)
      n += month_len(y, k);
    return n + d;
  endfunction

  function automatic res_t predict_period(req_t q);
    res_t p;
    int unsigned a;
    int unsigned b;
    p = '0;
    if (!valid_date(q.start_year, q.start_month, q.start_day) ||
        !valid_date(q.end_year, q.end_month, q.end_day)) begin
      p.date_invalid = 1'b1;
    end else begin
      a = day_number(q.start_year, q.start_month, q.start_day);
      b = day_number(q.end_year, q.end_month, q.end_day);
      p.day_count = 22'(((a < b) ? b - a : 0) + q.include_end_day);
    end
    return p;
  endfunction

  always @(posedge clk) begin
    period_expect_t oldest;
    if (rst) begin
      expected_periods.delete();
      pending <= 0;
    end else begin
      // retire before pushing: a result never belongs to the transaction taken at its edge
      if (done) begin
        if (expected_periods.size() == 0) begin
          report_mismatch("result strobe with no transaction outstanding");
        end else begin
          oldest = expected_periods.pop_front();
          if (res.day_count !== oldest.r.day_count)
            report_mismatch($sformatf(
              "day_count %0d, expected %0d (%0d-%0d-%0d to %0d-%0d-%0d incl %0d)",
              res.day_count, oldest.r.day_count, oldest.q.start_year,
              oldest.q.start_month, oldest.q.start_day, oldest.q.end_year,
              oldest.q.end_month, oldest.q.end_day, oldest.q.include_end_day));
          if (res.date_invalid !== oldest.r.date_invalid)
            report_mismatch($sformatf(
              "date_invalid %0b, expected %0b (%0d-%0d-%0d to %0d-%0d-%0d)",
              res.date_invalid, oldest.r.date_invalid, oldest.q.start_year,
              oldest.q.start_month, oldest.q.start_day, oldest.q.end_year,
              oldest.q.end_month, oldest.q.end_day));
        end
      end
      if (start && !busy) begin
        oldest.q = req;
        oldest.r = predict_period(req);
        expected_periods.push_back(oldest);
      end
      pending <= expected_periods.size();
    end
  end

endmodule

// File: bench/calendar_period_length_days_core_tb.sv
// Testbench top for the period length core: stimulus, watchdog and verdict.
module calendar_period_length_days_core_tb;
  import cpld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  res_t res;
  int   errors;
  int   pending;
  int   idle_cycles = 0;
  int   idle_pct = 0;

  always #5 clk = ~clk;

  calendar_period_length_days_core dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .res  (res)
  );

  calendar_period_length_days_checker u_checker (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .res    (res),
    .errors (errors),
    .pending(pending)
  );

  // cycles with neither a request taken nor a result delivered
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(int unsigned sy, int unsigned sm, int unsigned sd,
                                    int unsigned ey, int unsigned em, int unsigned ed,
                                    int unsigned inc);
    req_t r;
    r.start_year      = 14'(sy);
    r.start_month     = 4'(sm);
    r.start_day       = 5'(sd);
    r.end_year        = 14'(ey);
    r.end_month       = 4'(em);
    r.end_day         = 5'(ed);
    r.include_end_day = 1'(inc);
    return r;
  endfunction

  function automatic int unsigned edge_year();
    case ($urandom_range(4))
      0:       return 0;
      1:       return 1;
      2:       return MAX_YEAR;
      3:       return MAX_YEAR + 1;
      default: return 16383;
    endcase
  endfunction

  function automatic req_t random_item();
    req_t        r;
    logic [63:0] raw;
    int unsigned kind;
    kind = $urandom_range(99);
    // days above 28 are sometimes past the end of the month
    r = make_req($urandom_range(1, MAX_YEAR), $urandom_range(1, 12),
                 ($urandom_range(4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28),
                 $urandom_range(1, MAX_YEAR), $urandom_range(1, 12),
                 ($urandom_range(4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28),
                 $urandom_range(1));
    if (kind < 25) begin
      // short periods, around month and year boundaries
      r.end_year = 14'(r.start_year + $urandom_range(1));
      if ($urandom_range(1)) r.end_month = r.start_month;
    end else if (kind < 35) begin
      r.end_year  = r.start_year;
      r.end_month = r.start_month;
      r.end_day   = 5'(r.start_day + $urandom_range(0, 2) - 1);
    end else if (kind < 45) begin
      r.start_year = 14'(edge_year());
      r.end_year   = 14'(edge_year());
    end else if (kind < 55) begin
      raw = {$urandom, $urandom};
      r   = raw[$bits(req_t)-1:0];
    end
    return r;
  endfunction

  task automatic issue(input req_t r);
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  endtask

  // hold off until every outstanding transaction has returned
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(make_req(1, 1, 1, 9999, 12, 31, 0));
    issue(make_req(1, 1, 1, 9999, 12, 31, 1));
    issue(make_req(2024, 3, 15, 2024, 3, 15, 0));
    issue(make_req(2024, 3, 15, 2024, 3, 15, 1));
    issue(make_req(2024, 3, 16, 2024, 3, 15, 1));
    issue(make_req(9999, 12, 31, 1, 1, 1, 1));
    issue(make_req(2000, 2, 28, 2000, 3, 1, 0));
    issue(make_req(1900, 2, 28, 1900, 3, 1, 0));
    issue(make_req(2000, 2, 29, 2004, 2, 29, 1));
    issue(make_req(2400, 2, 29, 2400, 3, 1, 0));
    issue(make_req(1900, 2, 29, 1901, 1, 1, 0));
    issue(make_req(2100, 2, 29, 2101, 1, 1, 1));
    issue(make_req(2023, 1, 1, 2023, 2, 29, 1));
    issue(make_req(2023, 1, 1, 2023, 0, 5, 0));
    issue(make_req(2023, 13, 1, 2024, 1, 1, 1));
    issue(make_req(2023, 15, 31, 2024, 1, 1, 0));
    issue(make_req(2023, 1, 1, 2023, 4, 31, 0));
    issue(make_req(2023, 1, 0, 2023, 5, 1, 1));
    issue(make_req(2023, 1, 31, 2023, 12, 31, 0));
    issue(make_req(0, 1, 1, 2023, 1, 1, 1));
    issue(make_req(1, 1, 1, 10000, 1, 1, 0));
    issue(make_req(16383, 15, 31, 16383, 15, 31, 1));
    issue('0);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 63 : (phase == 3) ? 13 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 4; n++)
        issue(random_item());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
